// ----- rtl/hse_pkg.sv -----
package hse_pkg;

  localparam int unsigned DATA_W = 32;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     is_last;
  } hse_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     end_of_run;
    logic                     overflowed;
  } hse_out_t;

  localparam logic ORDER_DESC = 1'b0;
  localparam logic ORDER_ASC  = 1'b1;

  // true when child c belongs above parent p
  function automatic logic beats(input logic signed [DATA_W-1:0] p,
                                 input logic signed [DATA_W-1:0] c,
                                 input logic                     order);
    logic r;
    if (order == ORDER_ASC) begin
      r = (p > c);
    end else begin
      r = (p < c);
    end
    return r;
  endfunction

endpackage

// ----- rtl/hse_heap_ram.sv -----
module hse_heap_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [AW-1:0]                     waddr,
  input  logic signed [hse_pkg::DATA_W-1:0] wdata,
  input  logic [AW-1:0]                     raddr_a,
  input  logic [AW-1:0]                     raddr_b,
  output logic signed [hse_pkg::DATA_W-1:0] rdata_a,
  output logic signed [hse_pkg::DATA_W-1:0] rdata_b
);
  import hse_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- rtl/hse_seq.sv -----
module hse_seq #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  hse_pkg::hse_in_t                  in_data,
  input  logic                              sort_order,
  output logic                              out_strobe,
  output hse_pkg::hse_out_t                 out_data,
  output logic                              ram_we,
  output logic [AW-1:0]                     ram_waddr,
  output logic signed [hse_pkg::DATA_W-1:0] ram_wdata,
  output logic [AW-1:0]                     ram_raddr_a,
  output logic [AW-1:0]                     ram_raddr_b,
  input  logic signed [hse_pkg::DATA_W-1:0] ram_rdata_a,
  input  logic signed [hse_pkg::DATA_W-1:0] ram_rdata_b
);
  import hse_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_HEAP_RD  = 7'b0000010,
    ST_HEAP_X   = 7'b0000100,
    ST_SIFT_RD  = 7'b0001000,
    ST_SIFT_CMP = 7'b0010000,
    ST_EXT_RD   = 7'b0100000,
    ST_EXT_OUT  = 7'b1000000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [CW-1:0]          idx_r, idx_nxt;
  logic [CW-1:0]          pos_r, pos_nxt;
  logic                   drop_r, drop_nxt;
  logic                   heapify_r, heapify_nxt;
  logic                   have_r, have_nxt;
  logic signed [DATA_W-1:0] x_r, x_nxt;
  logic                   out_strobe_r, out_strobe_nxt;
  hse_out_t               out_data_r, out_data_nxt;

  logic                   full;
  logic [CW-1:0]          n_ld;
  logic [CW-1:0]          pos_m1;
  logic [CW:0]            left;
  logic [CW:0]            n_ext;
  logic                   left_win;
  logic                   right_win;
  logic signed [DATA_W-1:0] pick;

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  assign full   = (cnt_r == CW'(DEPTH));
  assign n_ld   = full ? cnt_r : cnt_r + 1'b1;
  assign pos_m1 = pos_r - 1'b1;
  assign left   = {pos_r, 1'b0};
  assign n_ext  = {1'b0, cnt_r};

  assign left_win  = beats(x_r, ram_rdata_a, sort_order);
  assign pick      = left_win ? ram_rdata_a : x_r;
  assign right_win = have_r && beats(pick, ram_rdata_b, sort_order);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    drop_nxt       = drop_r;
    heapify_nxt    = heapify_r;
    have_nxt       = have_r;
    x_nxt          = x_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_waddr      = cnt_r[AW-1:0];
    ram_wdata      = in_data.value;
    ram_raddr_a    = '0;
    ram_raddr_b    = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (full) begin
            drop_nxt = 1'b1;
          end else begin
            ram_we = 1'b1;
          end
          cnt_nxt = n_ld;
          if (in_data.is_last) begin
            idx_nxt = n_ld >> 1;
            if ((n_ld >> 1) == '0) begin
              heapify_nxt = 1'b0;
              state_nxt   = ST_EXT_RD;
            end else begin
              heapify_nxt = 1'b1;
              state_nxt   = ST_HEAP_RD;
            end
          end
        end
      end
      ST_HEAP_RD: begin
        ram_raddr_a = AW'(idx_r - 1'b1);
        state_nxt   = ST_HEAP_X;
      end
      ST_HEAP_X: begin
        x_nxt     = ram_rdata_a;
        pos_nxt   = idx_r;
        state_nxt = ST_SIFT_RD;
      end
      ST_SIFT_RD: begin
        if (left <= n_ext) begin
          ram_raddr_a = AW'(left - 1'b1);
          ram_raddr_b = left[AW-1:0];
          have_nxt    = (left < n_ext);
          state_nxt   = ST_SIFT_CMP;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = pos_m1[AW-1:0];
          ram_wdata = x_r;
          if (heapify_r && idx_r != CW'(1)) begin
            idx_nxt   = idx_r - 1'b1;
            state_nxt = ST_HEAP_RD;
          end else begin
            heapify_nxt = 1'b0;
            state_nxt   = ST_EXT_RD;
          end
        end
      end
      ST_SIFT_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = pos_m1[AW-1:0];
        if (right_win) begin
          ram_wdata = ram_rdata_b;
          pos_nxt   = CW'(left + 1'b1);
          state_nxt = ST_SIFT_RD;
        end else if (left_win) begin
          ram_wdata = ram_rdata_a;
          pos_nxt   = left[CW-1:0];
          state_nxt = ST_SIFT_RD;
        end else begin
          ram_wdata = x_r;
          if (heapify_r && idx_r != CW'(1)) begin
            idx_nxt   = idx_r - 1'b1;
            state_nxt = ST_HEAP_RD;
          end else begin
            heapify_nxt = 1'b0;
            state_nxt   = ST_EXT_RD;
          end
        end
      end
      ST_EXT_RD: begin
        ram_raddr_a = '0;
        ram_raddr_b = AW'(cnt_r - 1'b1);
        state_nxt   = ST_EXT_OUT;
      end
      ST_EXT_OUT: begin
        out_strobe_nxt            = 1'b1;
        out_data_nxt.sorted_value = ram_rdata_a;
        out_data_nxt.end_of_run   = (cnt_r == CW'(1));
        out_data_nxt.overflowed   = drop_r;
        if (cnt_r == CW'(1)) begin
          cnt_nxt   = '0;
          drop_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          x_nxt     = ram_rdata_b;
          cnt_nxt   = cnt_r - 1'b1;
          pos_nxt   = CW'(1);
          state_nxt = ST_SIFT_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      idx_r        <= '0;
      pos_r        <= '0;
      drop_r       <= 1'b0;
      heapify_r    <= 1'b0;
      have_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      idx_r        <= idx_nxt;
      pos_r        <= pos_nxt;
      drop_r       <= drop_nxt;
      heapify_r    <= heapify_nxt;
      have_r       <= have_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ----- rtl/heap_sort_engine_unit.sv -----
// Loading: one transaction per cycle, no result; busy stays low between items.
// Sorting (item with is_last, n values held): busy, takes no item; the heap is built
// by sifting down each internal node in turn, then each result is read from the
// root and the heap re-sifted, bounded by the one shared two-read, one-write store.
// Results are strobed for one cycle each; the receiver cannot stall.
// rst_n (synchronous) clears control state and sort_order; heap store is not cleared.
module heap_sort_engine_unit #(
  parameter int unsigned DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  hse_pkg::hse_in_t  in_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data,
  output logic              out_strobe,
  output hse_pkg::hse_out_t out_data
);
  import hse_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic                     sort_order_r;
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic signed [DATA_W-1:0] ram_wdata;
  logic [AW-1:0]            ram_raddr_a;
  logic [AW-1:0]            ram_raddr_b;
  logic signed [DATA_W-1:0] ram_rdata_a;
  logic signed [DATA_W-1:0] ram_rdata_b;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sort_order_r <= ORDER_DESC;
    end else if (cfg_valid && cfg_ready) begin
      sort_order_r <= cfg_data;
    end
  end

  hse_heap_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  hse_seq #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .sort_order  (sort_order_r),
    .out_strobe  (out_strobe),
    .out_data    (out_data),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr_a (ram_raddr_a),
    .ram_raddr_b (ram_raddr_b),
    .ram_rdata_a (ram_rdata_a),
    .ram_rdata_b (ram_rdata_b)
  );

  a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobed without a sort in progress");

  a_end_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.end_of_run) |-> !busy)
    else $error("still busy after final result");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_data.is_last) |=> !busy)
    else $error("non-final transaction left engine busy");

  a_last_starts_sort: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.is_last) |=> busy)
    else $error("final transaction did not start a sort");

endmodule
